[src/llwd_pkg.sv]
// ----------------------------------------------------------------------------
// llwd_pkg - shared types and constants for the worker dispatcher
// Request and response payload structs, command codes and field widths.
// ----------------------------------------------------------------------------
package llwd_pkg;

   // default sizing
   localparam int MAX_WORKERS_DEF = 16;
   localparam int TIME_BITS_DEF   = 32;

   // fixed field widths
   localparam int SLOT_BITS    = 4;
   localparam int LOAD_BITS    = 10;
   localparam int COUNT_BITS   = 5;
   localparam int TIMEOUT_BITS = 16;

   localparam logic [LOAD_BITS-1:0]    LOAD_MAX      = '1;
   localparam logic [TIMEOUT_BITS-1:0] TIMEOUT_RESET = 16'd30;

   // command codes
   typedef enum logic [2:0] {
      CMD_REGISTER  = 3'd0,
      CMD_HEARTBEAT = 3'd1,
      CMD_DEAD      = 3'd2,
      CMD_SELECT    = 3'd3,
      CMD_RELEASE   = 3'd4,
      CMD_TICK      = 3'd5,
      CMD_REAP      = 3'd6
   } cmd_type;

   typedef struct packed {
      logic [2:0]           command;
      logic [SLOT_BITS-1:0] worker_slot;
      logic [LOAD_BITS-1:0] reported_load;
   } req_type;

   typedef struct packed {
      logic                  found;
      logic [SLOT_BITS-1:0]  chosen_slot;
      logic                  known;
      logic [COUNT_BITS-1:0] alive_count;
      logic [COUNT_BITS-1:0] registered_count;
      logic                  any_alive;
   } rsp_type;

endpackage

[src/llwd_ram.sv]
// ----------------------------------------------------------------------------
// llwd_ram - generic single write, single read synchronous RAM
// One write port and one read port, read data registered.
// ----------------------------------------------------------------------------
module llwd_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   // registered read port
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

[src/llwd_seq.sv]
// ----------------------------------------------------------------------------
// llwd_seq - command sequencer for the worker table
// Keeps per-slot registered/alive bits and their counts, the tick counter,
// and the load/last-beat RAM. Runs one request at a time: direct updates,
// read-modify-write for release, and a one-slot-per-cycle scan for select
// and reap.
// ----------------------------------------------------------------------------
module llwd_seq #(
   parameter int MAX_WORKERS = llwd_pkg::MAX_WORKERS_DEF,
   parameter int TIME_BITS   = llwd_pkg::TIME_BITS_DEF
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_stall,
   input  llwd_pkg::req_type                 req_data,
   input  logic [llwd_pkg::TIMEOUT_BITS-1:0] timeout,
   output logic                              res_valid,
   input  logic                              res_take,
   output llwd_pkg::rsp_type                 res_data
);

   localparam int IW = $clog2(MAX_WORKERS);
   localparam int CW = $clog2(MAX_WORKERS + 1);
   localparam int LB = llwd_pkg::LOAD_BITS;
   localparam int WW = LB + TIME_BITS;

   typedef enum logic [6:0] {
      ST_IDLE = 7'b0000001,
      ST_EXEC = 7'b0000010,
      ST_RMW  = 7'b0000100,
      ST_SCAN = 7'b0001000,
      ST_LAST = 7'b0010000,
      ST_WB   = 7'b0100000,
      ST_DONE = 7'b1000000
   } state_type;

   state_type state_ff, state_in;

   logic [MAX_WORKERS-1:0] reg_ff, reg_in;
   logic [MAX_WORKERS-1:0] alive_ff, alive_in;
   logic [CW-1:0]          reg_cnt_ff, reg_cnt_in;
   logic [CW-1:0]          alive_cnt_ff, alive_cnt_in;
   logic [TIME_BITS-1:0]   now_ff, now_in;
   logic [IW-1:0]          scan_idx_ff, scan_idx_in;
   logic                   rd_vld_ff, rd_vld_in;
   logic [IW-1:0]          rd_idx_ff;

   llwd_pkg::req_type      cur_ff;
   logic                   known_ff, known_in;
   logic                   have_ff, have_in;
   logic [IW-1:0]          best_idx_ff, best_idx_in;
   logic [LB-1:0]          best_load_ff, best_load_in;
   logic [TIME_BITS-1:0]   best_beat_ff, best_beat_in;

   logic                   accept;
   logic                   slot_ok;
   logic [IW-1:0]          slot_idx;
   logic                   was_known;
   logic                   proc;
   logic                   is_select;

   logic                   ram_wr_en;
   logic [IW-1:0]          ram_wr_addr;
   logic [WW-1:0]          ram_wr_data;
   logic                   ram_rd_en;
   logic [IW-1:0]          ram_rd_addr;
   logic [WW-1:0]          ram_rd_data;
   logic [LB-1:0]          rd_load;
   logic [TIME_BITS-1:0]   rd_beat;
   logic [TIME_BITS-1:0]   age;

   // load and last-beat table
   llwd_ram #(
      .WIDTH(WW),
      .DEPTH(MAX_WORKERS)
   ) u_table (
      .clock  (clock),
      .wr_en  (ram_wr_en),
      .wr_addr(ram_wr_addr),
      .wr_data(ram_wr_data),
      .rd_en  (ram_rd_en),
      .rd_addr(ram_rd_addr),
      .rd_data(ram_rd_data)
   );

   // request decode
   assign req_stall = (state_ff != ST_IDLE);
   assign accept    = req_valid && !req_stall;
   assign slot_ok   = (32'(cur_ff.worker_slot) < MAX_WORKERS);
   assign slot_idx  = IW'(cur_ff.worker_slot);
   assign was_known = slot_ok && reg_ff[slot_idx];
   assign is_select = (cur_ff.command == llwd_pkg::CMD_SELECT);

   // table read data fields
   assign rd_load = ram_rd_data[WW-1 -: LB];
   assign rd_beat = ram_rd_data[TIME_BITS-1:0];
   assign age     = now_ff - rd_beat;
   assign proc    = ((state_ff == ST_SCAN) && rd_vld_ff) || (state_ff == ST_LAST);

   // sequencer next state and table updates
   always_comb begin
      state_in     = state_ff;
      reg_in       = reg_ff;
      alive_in     = alive_ff;
      reg_cnt_in   = reg_cnt_ff;
      alive_cnt_in = alive_cnt_ff;
      now_in       = now_ff;
      scan_idx_in  = scan_idx_ff;
      rd_vld_in    = 1'b0;
      known_in     = known_ff;
      have_in      = have_ff;
      best_idx_in  = best_idx_ff;
      best_load_in = best_load_ff;
      best_beat_in = best_beat_ff;
      ram_wr_en    = 1'b0;
      ram_wr_addr  = slot_idx;
      ram_wr_data  = {LB'(0), now_ff};
      ram_rd_en    = 1'b0;
      ram_rd_addr  = slot_idx;

      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               state_in = ST_EXEC;
               have_in  = 1'b0;
               known_in = 1'b0;
            end
         end
         ST_EXEC: begin
            state_in = ST_DONE;
            case (cur_ff.command)
               llwd_pkg::CMD_REGISTER: begin
                  known_in = was_known;
                  if (slot_ok) begin
                     ram_wr_en        = 1'b1;
                     reg_in[slot_idx]   = 1'b1;
                     alive_in[slot_idx] = 1'b1;
                     if (!reg_ff[slot_idx]) begin
                        reg_cnt_in = reg_cnt_ff + CW'(1);
                     end
                     if (!alive_ff[slot_idx]) begin
                        alive_cnt_in = alive_cnt_ff + CW'(1);
                     end
                  end
               end
               llwd_pkg::CMD_HEARTBEAT: begin
                  known_in = was_known;
                  if (was_known) begin
                     ram_wr_en   = 1'b1;
                     ram_wr_data = {cur_ff.reported_load, now_ff};
                     alive_in[slot_idx] = 1'b1;
                     if (!alive_ff[slot_idx]) begin
                        alive_cnt_in = alive_cnt_ff + CW'(1);
                     end
                  end
               end
               llwd_pkg::CMD_DEAD: begin
                  known_in = was_known;
                  if (was_known && alive_ff[slot_idx]) begin
                     alive_in[slot_idx] = 1'b0;
                     alive_cnt_in       = alive_cnt_ff - CW'(1);
                  end
               end
               llwd_pkg::CMD_RELEASE: begin
                  known_in  = was_known;
                  ram_rd_en = 1'b1;
                  state_in  = ST_RMW;
               end
               llwd_pkg::CMD_TICK: begin
                  now_in = now_ff + TIME_BITS'(1);
               end
               llwd_pkg::CMD_SELECT, llwd_pkg::CMD_REAP: begin
                  scan_idx_in = '0;
                  state_in    = ST_SCAN;
               end
               default: begin
                  state_in = ST_DONE;
               end
            endcase
         end
         ST_RMW: begin
            // release: decrement load, keep last beat
            if (known_ff && (rd_load != '0)) begin
               ram_wr_en   = 1'b1;
               ram_wr_data = {rd_load - LB'(1), rd_beat};
            end
            state_in = ST_DONE;
         end
         ST_SCAN: begin
            ram_rd_en   = 1'b1;
            ram_rd_addr = scan_idx_ff;
            rd_vld_in   = 1'b1;
            if (scan_idx_ff == IW'(MAX_WORKERS - 1)) begin
               state_in = ST_LAST;
            end else begin
               scan_idx_in = scan_idx_ff + IW'(1);
            end
         end
         ST_LAST: begin
            state_in = is_select ? ST_WB : ST_DONE;
         end
         ST_WB: begin
            // reserve the chosen worker, load saturates
            if (have_ff) begin
               ram_wr_en   = 1'b1;
               ram_wr_addr = best_idx_ff;
               ram_wr_data = {(best_load_ff == llwd_pkg::LOAD_MAX) ? best_load_ff
                                                                 : best_load_ff + LB'(1),
                              best_beat_ff};
            end
            state_in = ST_DONE;
         end
         ST_DONE: begin
            if (res_take) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase

      // scan step on the slot whose data just came back
      if (proc && alive_ff[rd_idx_ff]) begin
         if (is_select) begin
            if (!have_ff || (rd_load < best_load_ff)) begin
               have_in      = 1'b1;
               best_idx_in  = rd_idx_ff;
               best_load_in = rd_load;
               best_beat_in = rd_beat;
            end
         end else if (age > TIME_BITS'(timeout)) begin
            alive_in[rd_idx_ff] = 1'b0;
            alive_cnt_in        = alive_cnt_ff - CW'(1);
         end
      end
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         reg_ff       <= '0;
         alive_ff     <= '0;
         reg_cnt_ff   <= '0;
         alive_cnt_ff <= '0;
         now_ff       <= '0;
         rd_vld_ff    <= 1'b0;
      end else begin
         state_ff     <= state_in;
         reg_ff       <= reg_in;
         alive_ff     <= alive_in;
         reg_cnt_ff   <= reg_cnt_in;
         alive_cnt_ff <= alive_cnt_in;
         now_ff       <= now_in;
         rd_vld_ff    <= rd_vld_in;
      end
   end

   // request and scan payload registers
   always_ff @(posedge clock) begin
      if (accept) begin
         cur_ff <= req_data;
      end
      scan_idx_ff  <= scan_idx_in;
      rd_idx_ff    <= scan_idx_ff;
      known_ff     <= known_in;
      have_ff      <= have_in;
      best_idx_ff  <= best_idx_in;
      best_load_ff <= best_load_in;
      best_beat_ff <= best_beat_in;
   end

   // response fields
   always_comb begin
      res_valid                 = (state_ff == ST_DONE);
      res_data.found            = is_select && have_ff;
      res_data.chosen_slot      = (is_select && have_ff) ? llwd_pkg::SLOT_BITS'(best_idx_ff)
                                                         : '0;
      res_data.known            = known_ff;
      res_data.alive_count      = llwd_pkg::COUNT_BITS'(alive_cnt_ff);
      res_data.registered_count = llwd_pkg::COUNT_BITS'(reg_cnt_ff);
      res_data.any_alive        = (alive_cnt_ff != '0);
   end

`ifndef SYNTHESIS
   // alive slots are always registered
   a_alive_in_reg: assert property (@(posedge clock) disable iff (reset)
      (alive_ff & ~reg_ff) == '0)
      else $error("alive slot that is not registered");

   // running counts track the bit vectors
   a_alive_count: assert property (@(posedge clock) disable iff (reset)
      32'(alive_cnt_ff) == $countones(alive_ff))
      else $error("alive count out of step");

   a_reg_count: assert property (@(posedge clock) disable iff (reset)
      32'(reg_cnt_ff) == $countones(reg_ff))
      else $error("registered count out of step");

   // the scan tail processes the last slot
   a_scan_last: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_LAST) |-> (rd_vld_ff && (rd_idx_ff == IW'(MAX_WORKERS - 1))))
      else $error("scan ended before the last slot");

   // no table write while a scan is in flight
   a_scan_no_write: assert property (@(posedge clock) disable iff (reset)
      ((state_ff == ST_SCAN) || (state_ff == ST_LAST)) |-> !ram_wr_en)
      else $error("table write during scan");
`endif

endmodule

[src/least_loaded_worker_dispatcher.sv]
// ----------------------------------------------------------------------------
// least_loaded_worker_dispatcher - least loaded dispatch with heartbeat timeout
// Worker slot table with register, heartbeat, mark dead, select-and-reserve,
// release, tick and reap commands; one response per request.
//
//   channel  ports                            dir  handshake
//   request  req_valid req_stall req_data     in   valid && !stall
//   response rsp_valid rsp_stall rsp_data     out  valid && !stall
//   csr      csr_valid csr_ready csr_wdata    in   valid && ready (timeout)
//
// Register, heartbeat, mark dead, tick: execute state, then done state.
// Release: execute, read-modify-write of the load/beat RAM, then done.
// Select and reap: execute, then a one-slot-per-cycle scan over the RAM
// read port; select then writes back its reservation before done.
// Reset is synchronous; it clears all slot bits, counts and the tick count.
// A stalled response holds in the output register; the next request is
// accepted while it waits and its result is kept until the register frees.
// ----------------------------------------------------------------------------
module least_loaded_worker_dispatcher #(
   parameter int MAX_WORKERS = llwd_pkg::MAX_WORKERS_DEF,
   parameter int TIME_BITS   = llwd_pkg::TIME_BITS_DEF
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_stall,
   input  llwd_pkg::req_type                 req_data,
   output logic                              rsp_valid,
   input  logic                              rsp_stall,
   output llwd_pkg::rsp_type                 rsp_data,
   input  logic                              csr_valid,
   output logic                              csr_ready,
   input  logic [llwd_pkg::TIMEOUT_BITS-1:0] csr_wdata
);

   logic [llwd_pkg::TIMEOUT_BITS-1:0] timeout_ff, timeout_in;
   logic                              rsp_valid_ff, rsp_valid_in;
   llwd_pkg::rsp_type                 rsp_data_ff;
   logic                              res_valid;
   logic                              res_take;
   llwd_pkg::rsp_type                 res_data;

   // command sequencer and table
   llwd_seq #(
      .MAX_WORKERS(MAX_WORKERS),
      .TIME_BITS  (TIME_BITS)
   ) u_seq (
      .clock    (clock),
      .reset    (reset),
      .req_valid(req_valid),
      .req_stall(req_stall),
      .req_data (req_data),
      .timeout  (timeout_ff),
      .res_valid(res_valid),
      .res_take (res_take),
      .res_data (res_data)
   );

   // timeout register
   assign csr_ready  = 1'b1;
   assign timeout_in = (csr_valid && csr_ready) ? csr_wdata : timeout_ff;

   // output register
   assign res_take     = res_valid && (!rsp_valid_ff || !rsp_stall);
   assign rsp_valid_in = res_take ? 1'b1 : (rsp_valid_ff && rsp_stall);

   always_ff @(posedge clock) begin
      if (reset) begin
         timeout_ff   <= llwd_pkg::TIMEOUT_RESET;
         rsp_valid_ff <= 1'b0;
      end else begin
         timeout_ff   <= timeout_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (res_take) begin
         rsp_data_ff <= res_data;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

[test/testbench.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench - regression for the least loaded worker dispatcher
// Drives register, heartbeat, mark dead, select, release, tick and reap
// requests, including the unused command code, under random valid gaps and
// response stalls. It also applies one long receiver hold-off. Each response
// is checked against a slot table kept alongside the block. The timeout
// register is set to 1, 65535, 3 and a random value between phases.
// ----------------------------------------------------------------------------
module testbench;
   import llwd_pkg::*;

   localparam int          SLOTS           = 16;
   localparam int          PHASE_ITEMS     = 330;
   localparam int          HOLD_OFF_CYCLES = 300;
   localparam int          QUIET_LIMIT     = 5000;
   localparam int          DRAIN_CYCLES    = 40;
   localparam logic [2:0]  CMD_UNUSED      = 3'd7;

   // slot table mirror and queue of pending responses
   class dispatch_scoreboard;
      logic                    registered [SLOTS];
      logic                    alive      [SLOTS];
      logic [LOAD_BITS-1:0]    load       [SLOTS];
      logic [31:0]             last_beat  [SLOTS];
      logic [31:0]             now_ticks;
      logic [TIMEOUT_BITS-1:0] timeout;
      rsp_type                 pending_rsp [$];
      int                      errors;
      int                      requests;
      int                      grants;
      int                      reaped;

      function new();
         for (int i = 0; i < SLOTS; i++) begin
            registered[i] = 1'b0;
            alive[i]      = 1'b0;
            load[i]       = '0;
            last_beat[i]  = '0;
         end
         now_ticks = '0;
         timeout   = TIMEOUT_RESET;
         errors    = 0;
         requests  = 0;
         grants    = 0;
         reaped    = 0;
      endfunction

      function void set_timeout(logic [TIMEOUT_BITS-1:0] value);
         timeout = value;
      endfunction

      // apply one accepted request to the table and queue its response
      function void note_request(req_type req);
         rsp_type     want;
         int          s;
         int          best;
         logic        was_known;
         logic [31:0] age;
         logic [4:0]  n_alive;
         logic [4:0]  n_reg;

         s         = int'(req.worker_slot);
         was_known = registered[s];
         want      = '0;
         requests++;
         case (req.command)
            CMD_REGISTER: begin
               want.known    = was_known;
               registered[s] = 1'b1;
               alive[s]      = 1'b1;
               load[s]       = '0;
               last_beat[s]  = now_ticks;
            end
            CMD_HEARTBEAT: begin
               want.known = was_known;
               if (was_known) begin
                  alive[s]     = 1'b1;
                  load[s]      = req.reported_load;
                  last_beat[s] = now_ticks;
               end
            end
            CMD_DEAD: begin
               want.known = was_known;
               if (was_known) alive[s] = 1'b0;
            end
            CMD_SELECT: begin
               // least loaded alive slot, lowest index wins ties
               best = -1;
               for (int i = 0; i < SLOTS; i++) begin
                  if (alive[i] && (best < 0 || load[i] < load[best])) best = i;
               end
               if (best >= 0) begin
                  if (load[best] != LOAD_MAX) load[best]++;
                  want.found       = 1'b1;
                  want.chosen_slot = 4'(best);
                  grants++;
               end
            end
            CMD_RELEASE: begin
               want.known = was_known;
               if (was_known && load[s] != 0) load[s]--;
            end
            CMD_TICK: now_ticks++;
            CMD_REAP: begin
               for (int i = 0; i < SLOTS; i++) begin
                  age = now_ticks - last_beat[i];
                  if (alive[i] && age > {16'd0, timeout}) begin
                     alive[i] = 1'b0;
                     reaped++;
                  end
               end
            end
            default: ;
         endcase

         n_alive = '0;
         n_reg   = '0;
         for (int i = 0; i < SLOTS; i++) begin
            n_alive += alive[i];
            n_reg   += registered[i];
         end
         want.alive_count      = n_alive;
         want.registered_count = n_reg;
         want.any_alive        = (n_alive != 0);
         pending_rsp = {pending_rsp, want};
      endfunction

      function void mismatch(string field, int want, int got);
         errors++;
         if (errors <= 40)
            $display("%0t: %s mismatch, expected %0d, got %0d", $time, field, want, got);
      endfunction

      // compare one accepted response with the oldest pending one
      function void check_response(rsp_type got);
         rsp_type want;
         if (pending_rsp.size() == 0) begin
            errors++;
            $display("%0t: response %h with no request pending", $time, got);
            return;
         end
         want = pending_rsp.pop_front();
         if (got.found !== want.found) mismatch("found", want.found, got.found);
         if (got.chosen_slot !== want.chosen_slot)
            mismatch("chosen_slot", want.chosen_slot, got.chosen_slot);
         if (got.known !== want.known) mismatch("known", want.known, got.known);
         if (got.alive_count !== want.alive_count)
            mismatch("alive_count", want.alive_count, got.alive_count);
         if (got.registered_count !== want.registered_count)
            mismatch("registered_count", want.registered_count, got.registered_count);
         if (got.any_alive !== want.any_alive)
            mismatch("any_alive", want.any_alive, got.any_alive);
      endfunction
   endclass

   logic                    clock = 1'b0;
   logic                    reset;
   logic                    req_valid;
   logic                    req_stall;
   req_type                 req_data;
   logic                    rsp_valid;
   logic                    rsp_stall;
   rsp_type                 rsp_data;
   logic                    csr_valid;
   logic                    csr_ready;
   logic [TIMEOUT_BITS-1:0] csr_wdata;

   dispatch_scoreboard sb = new();
   logic               quiet        = 1'b0;
   logic               hold_off_req = 1'b0;

   least_loaded_worker_dispatcher dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_wdata (csr_wdata)
   );

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   // observe handshakes on every edge, responses before new requests
   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_valid && !rsp_stall) sb.check_response(rsp_data);
         if (req_valid && !req_stall) sb.note_request(req_data);
         if (csr_valid && csr_ready) sb.set_timeout(csr_wdata);
      end
   end

   // receiver stalls: random, none while quiet, or one long hold-off
   initial begin : response_backpressure
      int hold_left;
      hold_left = 0;
      rsp_stall <= 1'b0;
      forever begin
         @(posedge clock);
         if (hold_left > 0) begin
            rsp_stall <= 1'b1;
            hold_left--;
         end else if (hold_off_req) begin
            hold_off_req = 1'b0;
            hold_left    = HOLD_OFF_CYCLES;
            rsp_stall <= 1'b1;
         end else begin
            rsp_stall <= !quiet && ($urandom_range(99) < 34);
         end
      end
   end

   // end the run when nothing moves for too long
   initial begin : watchdog
      int idle_cycles;
      idle_cycles = 0;
      while (idle_cycles < QUIET_LIMIT) begin
         @(posedge clock);
         if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall) ||
             (csr_valid && csr_ready))
            idle_cycles = 0;
         else
            idle_cycles++;
      end
      $display("%0t: no handshake for %0d cycles", $time, QUIET_LIMIT);
      $display("least_loaded_worker_dispatcher regression: fail");
      $finish;
   end

   // offer one request and wait for it to be taken, then maybe idle
   task automatic send(input logic [2:0] cmd, input logic [3:0] slot,
                       input logic [LOAD_BITS-1:0] ld);
      req_type item;
      item.command       = cmd;
      item.worker_slot   = slot;
      item.reported_load = ld;
      req_valid <= 1'b1;
      req_data  <= item;
      do @(posedge clock); while (req_stall);
      if (!quiet) begin
         while ($urandom_range(99) < 34) begin
            req_valid <= 1'b0;
            @(posedge clock);
         end
      end
   endtask

   task automatic send_random();
      int                   pick;
      logic [2:0]           cmd;
      logic [LOAD_BITS-1:0] ld;
      pick = $urandom_range(99);
      if (pick < 12)      cmd = CMD_REGISTER;
      else if (pick < 30) cmd = CMD_HEARTBEAT;
      else if (pick < 36) cmd = CMD_DEAD;
      else if (pick < 56) cmd = CMD_SELECT;
      else if (pick < 70) cmd = CMD_RELEASE;
      else if (pick < 85) cmd = CMD_TICK;
      else if (pick < 96) cmd = CMD_REAP;
      else                cmd = CMD_UNUSED;
      // mostly light loads so selections shift, some near saturation
      pick = $urandom_range(99);
      if (pick < 60)      ld = LOAD_BITS'($urandom_range(15));
      else if (pick < 80) ld = LOAD_BITS'($urandom_range(1023));
      else                ld = LOAD_BITS'($urandom_range(1023, 1000));
      send(cmd, 4'($urandom_range(15)), ld);
   endtask

   task automatic wait_for_drain();
      do @(negedge clock); while (sb.pending_rsp.size() != 0);
      @(posedge clock);
   endtask

   task automatic write_timeout(input logic [TIMEOUT_BITS-1:0] value);
      csr_wdata <= value;
      csr_valid <= 1'b1;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
   endtask

   initial begin : stimulus
      logic [TIMEOUT_BITS-1:0] phase_timeout [4];
      phase_timeout[0] = 16'd1;
      phase_timeout[1] = 16'hFFFF;
      phase_timeout[2] = 16'd3;
      phase_timeout[3] = TIMEOUT_BITS'($urandom_range(60, 2));

      reset     <= 1'b1;
      req_valid <= 1'b0;
      req_data  <= '0;
      csr_valid <= 1'b0;
      csr_wdata <= '0;
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed: empty table, unknown slots, ties, saturation, revival
      send(CMD_SELECT,    4'd0,  10'd0);
      send(CMD_HEARTBEAT, 4'd3,  10'd1023);
      send(CMD_DEAD,      4'd3,  10'd0);
      send(CMD_RELEASE,   4'd3,  10'd0);
      send(CMD_REGISTER,  4'd0,  10'd0);
      send(CMD_REGISTER,  4'd15, 10'd1023);
      send(CMD_REGISTER,  4'd0,  10'd0);
      send(CMD_REGISTER,  4'd5,  10'd0);
      send(CMD_REGISTER,  4'd7,  10'd0);
      send(CMD_SELECT,    4'd0,  10'd0);
      send(CMD_SELECT,    4'd0,  10'd0);
      send(CMD_HEARTBEAT, 4'd15, 10'd1023);
      send(CMD_HEARTBEAT, 4'd7,  10'd0);
      send(CMD_DEAD,      4'd0,  10'd0);
      send(CMD_DEAD,      4'd5,  10'd0);
      send(CMD_DEAD,      4'd7,  10'd0);
      send(CMD_SELECT,    4'd0,  10'd0);
      send(CMD_RELEASE,   4'd15, 10'd0);
      send(CMD_RELEASE,   4'd0,  10'd0);
      send(CMD_RELEASE,   4'd0,  10'd0);
      send(CMD_UNUSED,    4'd15, 10'd1023);
      send(CMD_TICK,      4'd0,  10'd0);
      send(CMD_REAP,      4'd0,  10'd0);
      send(CMD_HEARTBEAT, 4'd0,  10'd0);
      send(CMD_SELECT,    4'd0,  10'd0);

      // random phases, one timeout setting each
      for (int p = 0; p < 4; p++) begin
         req_valid <= 1'b0;
         wait_for_drain();
         write_timeout(phase_timeout[p]);
         if (p == 2) hold_off_req = 1'b1;
         for (int n = 0; n < PHASE_ITEMS; n++) begin
            quiet = (p == 1) && (n < 150);
            send_random();
         end
      end
      quiet = 1'b0;
      req_valid <= 1'b0;

      wait_for_drain();
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("checked %0d requests: %0d selections granted, %0d workers reaped",
               sb.requests, sb.grants, sb.reaped);
      $display("timeout set to 30, 1, 65535, 3 and %0d; one long response hold-off",
               phase_timeout[3]);
      if (sb.pending_rsp.size() != 0)
         $display("%0t: %0d responses never arrived", $time, sb.pending_rsp.size());
      if (sb.errors == 0 && sb.pending_rsp.size() == 0)
         $display("least_loaded_worker_dispatcher regression: pass");
      else
         $display("least_loaded_worker_dispatcher regression: fail");
      $finish;
   end

endmodule

[files.f]
src/llwd_pkg.sv
src/llwd_ram.sv
src/llwd_seq.sv
src/least_loaded_worker_dispatcher.sv
test/testbench.sv
